>>> src/dgh_pkg.sv
// Shared constants, types and helpers for the domino heat-bath block.
package dgh_pkg;

  localparam int MAX_SIZE      = 256;
  localparam int POS_BITS      = $clog2(MAX_SIZE);
  localparam int SIZE_BITS     = 9;
  localparam int ADDR_BITS     = 2 * POS_BITS;
  localparam int LATTICE_DEPTH = MAX_SIZE * MAX_SIZE;

  localparam int WEIGHT_BITS  = 16;
  localparam int UNIFORM_BITS = 16;
  localparam int PROD_BITS    = 2 * WEIGHT_BITS;
  localparam int MUL_A_BITS   = PROD_BITS;
  localparam int MUL_B_BITS   = UNIFORM_BITS + 1;
  localparam int MUL_P_BITS   = MUL_A_BITS + MUL_B_BITS;

  localparam int PADDR_BITS   = 4;
  localparam int PDATA_BITS   = 32;
  localparam int REG_IDX_BITS = PADDR_BITS - 2;
  localparam int CMD_BITS     = 2;
  localparam int ORI_BITS     = 2;
  localparam int STEP_BITS    = 3;

  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = WEIGHT_BITS'(4096);
  localparam logic [SIZE_BITS-1:0]   SIZE_RESET   = SIZE_BITS'(256);
  localparam logic [SIZE_BITS-1:0]   SIZE_MAX     = SIZE_BITS'(MAX_SIZE);

  localparam logic [UNIFORM_BITS-1:0] UNIFORM_HALF = {1'b1, {(UNIFORM_BITS-1){1'b0}}};
  localparam logic [MUL_B_BITS-1:0]   UNIFORM_ONE  = {1'b1, {UNIFORM_BITS{1'b0}}};

  localparam logic [REG_IDX_BITS-1:0] REG_WEIGHT_A     = REG_IDX_BITS'(0);
  localparam logic [REG_IDX_BITS-1:0] REG_WEIGHT_B     = REG_IDX_BITS'(1);
  localparam logic [REG_IDX_BITS-1:0] REG_LATTICE_SIZE = REG_IDX_BITS'(2);

  localparam logic [CMD_BITS-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_UPDATE = 2'd2;

  localparam logic [ORI_BITS-1:0] ORI_MIXED = 2'd0;
  localparam logic [ORI_BITS-1:0] ORI_HH    = 2'd1;
  localparam logic [ORI_BITS-1:0] ORI_VV    = 2'd2;

  localparam logic ST_OK    = 1'b0;
  localparam logic ST_RANGE = 1'b1;

  // plaquette bits: [0] NW, [1] NE, [2] SW, [3] SE
  localparam logic [3:0] QUAD_HH = 4'b1001;
  localparam logic [3:0] QUAD_VV = 4'b0110;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_READ,
    S_FETCH,
    S_CLASS,
    S_MUL,
    S_STORE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] weight_a;
    logic [WEIGHT_BITS-1:0] weight_b;
    logic [SIZE_BITS-1:0]   lattice_size;
  } cfg_t;

  typedef struct packed {
    logic                 en;
    logic [ADDR_BITS-1:0] addr;
    logic                 data;
  } lat_wr_t;

  function automatic logic site_is_b(logic [POS_BITS-1:0] r, logic [POS_BITS-1:0] c);
    return r[1] == c[1];
  endfunction

endpackage

>>> src/dgh_in_if.sv
// Command channel: valid/ready handshake with one command beat.
interface dgh_in_if;
  import dgh_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_BITS-1:0]     cmd;
  logic [POS_BITS-1:0]     row;
  logic [POS_BITS-1:0]     col;
  logic                    cell_in;
  logic [UNIFORM_BITS-1:0] uniform;

  modport source (output valid, cmd, row, col, cell_in, uniform, input ready);
  modport sink   (input valid, cmd, row, col, cell_in, uniform, output ready);
endinterface

>>> src/dgh_out_if.sv
// Result channel: valid/ready handshake with one result beat.
interface dgh_out_if;
  import dgh_pkg::*;

  logic                valid;
  logic                ready;
  logic                cell_out;
  logic                flipped;
  logic [ORI_BITS-1:0] orientation;
  logic                status;

  modport source (output valid, cell_out, flipped, orientation, status, input ready);
  modport sink   (input valid, cell_out, flipped, orientation, status, output ready);
endinterface

>>> src/dgh_cfg.sv
// APB-style configuration registers: site weights and lattice size.
module dgh_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dgh_pkg::PADDR_BITS-1:0]  paddr,
  input  logic [dgh_pkg::PDATA_BITS-1:0]  pwdata,
  output logic [dgh_pkg::PDATA_BITS-1:0]  prdata,
  output logic                            pready,
  output dgh_pkg::cfg_t                   cfg
);
  import dgh_pkg::*;

  logic                    wr_hit;
  logic [REG_IDX_BITS-1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[PADDR_BITS-1:2];
  assign wr_hit = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.weight_a     <= WEIGHT_RESET;
      cfg.weight_b     <= WEIGHT_RESET;
      cfg.lattice_size <= SIZE_RESET;
    end else if (wr_hit) begin
      case (idx)
        REG_WEIGHT_A:     cfg.weight_a     <= pwdata[WEIGHT_BITS-1:0];
        REG_WEIGHT_B:     cfg.weight_b     <= pwdata[WEIGHT_BITS-1:0];
        REG_LATTICE_SIZE: cfg.lattice_size <= pwdata[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WEIGHT_A:     prdata = PDATA_BITS'(cfg.weight_a);
      REG_WEIGHT_B:     prdata = PDATA_BITS'(cfg.weight_b);
      REG_LATTICE_SIZE: prdata = PDATA_BITS'(cfg.lattice_size);
      default:          prdata = '0;
    endcase
  end

endmodule

>>> src/dgh_lattice.sv
// Lattice marker memory with one read port, one write port and a clear sweep after reset.
module dgh_lattice (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [dgh_pkg::ADDR_BITS-1:0]  rd_addr,
  output logic                           rd_data,
  input  dgh_pkg::lat_wr_t               wr,
  output logic                           busy
);
  import dgh_pkg::*;

  logic                 mem [LATTICE_DEPTH];
  logic [ADDR_BITS-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= 1'b0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/dgh_mul.sv
// Shared multiplier with a registered product.
module dgh_mul (
  input  logic                            clk,
  input  logic [dgh_pkg::MUL_A_BITS-1:0]  a,
  input  logic [dgh_pkg::MUL_B_BITS-1:0]  b,
  output logic [dgh_pkg::MUL_P_BITS-1:0]  p
);
  import dgh_pkg::*;

  always_ff @(posedge clk) begin
    p <= MUL_P_BITS'(a) * MUL_P_BITS'(b);
  end

endmodule

>>> src/domino_glauber_heat_bath_top.sv
// Top level: command sequencer around the lattice memory and the shared multiplier.
// One command is handled at a time and every command returns one result beat. A load
// writes its cell, a read fetches its cell, an out-of-range or unused command goes
// straight to its result, and an update fetches its plaquette, ends there if the
// plaquette is mixed and otherwise redraws it through the multiplier and stores it. The
// block is ready again in the cycle after the result beat is taken. The four cell reads
// and four cell writes of an update go one at a time through the lattice memory's read
// port and write port. The two weight products and the two sides of the probability
// compare take four passes through the one multiplier. After reset the lattice is cleared
// one cell per cycle; no command is accepted during the sweep (register writes are).
module domino_glauber_heat_bath_top (
  input  logic                            clk,
  input  logic                            rst,
  dgh_in_if.sink                          in_ch,
  dgh_out_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dgh_pkg::PADDR_BITS-1:0]  paddr,
  input  logic [dgh_pkg::PDATA_BITS-1:0]  pwdata,
  output logic [dgh_pkg::PDATA_BITS-1:0]  prdata,
  output logic                            pready
);
  import dgh_pkg::*;

  cfg_t                    cfg;
  state_t                  state;
  state_t                  state_next;
  logic [STEP_BITS-1:0]    step;

  logic [SIZE_BITS-1:0]    n_use;
  logic                    accept;
  logic                    cell_ok;
  logic                    quad_ok;
  logic                    in_err;

  logic [CMD_BITS-1:0]     op_cmd;
  logic [POS_BITS-1:0]     op_row;
  logic [POS_BITS-1:0]     op_col;
  logic [POS_BITS-1:0]     op_row1;
  logic [POS_BITS-1:0]     op_col1;
  logic                    op_cell;
  logic [UNIFORM_BITS-1:0] op_u;

  logic [3:0]              quad;
  logic [3:0]              quad_new;
  logic [PROD_BITS-1:0]    whh;
  logic [PROD_BITS-1:0]    wvv;
  logic [MUL_P_BITS-1:0]   lhs;
  logic                    choose;

  logic                    res_cell;
  logic                    res_flipped;
  logic [ORI_BITS-1:0]     res_ori;
  logic                    res_status;

  logic [ADDR_BITS-1:0]    cell_addr;
  logic [ADDR_BITS-1:0]    rd_addr;
  logic                    rd_data;
  lat_wr_t                 lat_wr;
  logic                    lat_busy;

  logic [MUL_A_BITS-1:0]   mul_a;
  logic [MUL_B_BITS-1:0]   mul_b;
  logic [MUL_P_BITS-1:0]   mul_p;

  dgh_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dgh_lattice u_lattice (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (lat_wr),
    .busy    (lat_busy)
  );

  dgh_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign n_use   = (cfg.lattice_size > SIZE_MAX) ? SIZE_MAX : cfg.lattice_size;
  assign accept  = in_ch.valid && in_ch.ready;
  assign cell_ok = (SIZE_BITS'(in_ch.row) < n_use) && (SIZE_BITS'(in_ch.col) < n_use);
  assign quad_ok = ((SIZE_BITS'(in_ch.row) + SIZE_BITS'(1)) < n_use) &&
                   ((SIZE_BITS'(in_ch.col) + SIZE_BITS'(1)) < n_use);

  always_comb begin
    case (in_ch.cmd)
      CMD_LOAD:   in_err = !cell_ok;
      CMD_READ:   in_err = !cell_ok;
      CMD_UPDATE: in_err = !quad_ok;
      default:    in_err = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_err) begin
            state_next = S_DONE;
          end else begin
            case (in_ch.cmd)
              CMD_LOAD:   state_next = S_LOAD;
              CMD_READ:   state_next = S_READ;
              CMD_UPDATE: state_next = S_FETCH;
              default:    state_next = S_DONE;
            endcase
          end
        end
      end
      S_LOAD:  state_next = S_DONE;
      S_READ:  if (step == STEP_BITS'(1)) state_next = S_DONE;
      S_FETCH: if (step == STEP_BITS'(4)) state_next = S_CLASS;
      S_CLASS: begin
        if (quad == QUAD_HH || quad == QUAD_VV) begin
          state_next = S_MUL;
        end else begin
          state_next = S_DONE;
        end
      end
      S_MUL:   if (step == STEP_BITS'(4)) state_next = S_STORE;
      S_STORE: if (step == STEP_BITS'(3)) state_next = S_DONE;
      S_DONE:  if (out_ch.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  assign quad_new  = choose ? QUAD_HH : QUAD_VV;
  assign cell_addr = {step[1] ? op_row1 : op_row, step[0] ? op_col1 : op_col};

  always_comb begin
    in_ch.ready  = (state == S_IDLE) && !lat_busy;
    out_ch.valid = (state == S_DONE);
    rd_addr      = cell_addr;
    lat_wr.en    = (state == S_LOAD) || (state == S_STORE);
    lat_wr.addr  = cell_addr;
    lat_wr.data  = (state == S_LOAD) ? op_cell : quad_new[step[1:0]];
    mul_a        = '0;
    mul_b        = '0;
    if (state == S_MUL) begin
      case (step)
        3'd0: begin
          mul_a = MUL_A_BITS'(site_is_b(op_row, op_col) ? cfg.weight_b : cfg.weight_a);
          mul_b = MUL_B_BITS'(site_is_b(op_row1, op_col1) ? cfg.weight_b : cfg.weight_a);
        end
        3'd1: begin
          mul_a = MUL_A_BITS'(site_is_b(op_row1, op_col) ? cfg.weight_b : cfg.weight_a);
          mul_b = MUL_B_BITS'(site_is_b(op_row, op_col1) ? cfg.weight_b : cfg.weight_a);
        end
        3'd2: begin
          mul_a = mul_p[MUL_A_BITS-1:0];
          mul_b = MUL_B_BITS'(op_u);
        end
        3'd3: begin
          mul_a = whh;
          mul_b = UNIFORM_ONE - MUL_B_BITS'(op_u);
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  assign out_ch.cell_out    = res_cell;
  assign out_ch.flipped     = res_flipped;
  assign out_ch.orientation = res_ori;
  assign out_ch.status      = res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        step <= '0;
      end else begin
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          op_cmd      <= in_ch.cmd;
          op_row      <= in_ch.row;
          op_col      <= in_ch.col;
          op_row1     <= in_ch.row + 1'b1;
          op_col1     <= in_ch.col + 1'b1;
          op_cell     <= in_ch.cell_in;
          op_u        <= in_ch.uniform;
          res_cell    <= 1'b0;
          res_flipped <= 1'b0;
          res_ori     <= ORI_MIXED;
          res_status  <= in_err ? ST_RANGE : ST_OK;
        end
      end
      S_READ: begin
        if (step == STEP_BITS'(1) && op_cmd == CMD_READ) begin
          res_cell <= rd_data;
        end
      end
      S_FETCH: begin
        if (step != '0) begin
          quad[2'(step - 1'b1)] <= rd_data;
        end
      end
      S_MUL: begin
        case (step)
          3'd1: whh <= mul_p[PROD_BITS-1:0];
          3'd2: wvv <= mul_p[PROD_BITS-1:0];
          3'd3: lhs <= mul_p;
          3'd4: choose <= (whh == wvv) ? (op_u < UNIFORM_HALF) : (lhs < mul_p);
          default: ;
        endcase
      end
      S_STORE: begin
        if (step == STEP_BITS'(3)) begin
          res_flipped <= choose ? (quad == QUAD_VV) : (quad == QUAD_HH);
          res_ori     <= choose ? ORI_HH : ORI_VV;
        end
      end
      default: ;
    endcase
  end

  a_no_write_in_clear: assert property (@(posedge clk) disable iff (rst)
    lat_wr.en |-> !lat_busy)
    else $error("lattice write during clear sweep");

  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ch.ready)
    else $error("ready right after command accept");

  a_range_clean: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.status |->
      out_ch.orientation == ORI_MIXED && !out_ch.flipped && !out_ch.cell_out)
    else $error("range error result carries data");

  a_flip_oriented: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.flipped |-> out_ch.orientation != ORI_MIXED)
    else $error("flip reported without orientation");

endmodule
